// ===== design/sctc_pkg.sv =====
// shared types and codes for the sparse coordinate to compressed converter
package sctc_pkg;

    localparam int DIM_W   = 9;
    localparam int ROW_W   = 8;
    localparam int VAL_W   = 64;
    localparam int IDX_W   = 10;
    localparam int UNQ_W   = 11;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_CONVERT  = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOT_CONV = 2'd3;

    localparam logic [2:0] SEL_COLPTR = 3'd0;
    localparam logic [2:0] SEL_ROWIDX = 3'd1;
    localparam logic [2:0] SEL_VALUE  = 3'd2;
    localparam logic [2:0] SEL_ROWPTR = 3'd3;
    localparam logic [2:0] SEL_COLIDX = 3'd4;

    localparam logic [1:0] REG_NUM_ROWS     = 2'd0;
    localparam logic [1:0] REG_NUM_COLS     = 2'd1;
    localparam logic [1:0] REG_STORE_VALUES = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [VAL_W-1:0] entry_value;
        logic [2:0]       array_select;
        logic [IDX_W-1:0] read_index;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] read_data;
        logic [UNQ_W-1:0] unique_count;
    } out_t;

endpackage

// ===== design/sctc_alu.sv =====
// shared adder and comparator used by the load path and the conversion sequencer
module sctc_alu #(
    parameter int W = 11
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] c,
    input  logic [W-1:0] d,
    output logic [W-1:0] sum,
    output logic         lt
);
    assign sum = a + b;
    assign lt  = c < d;
endmodule

// ===== design/sparse_coordinate_to_compressed_core.sv =====
// top level: entry stores, config registers and conversion sequencer
// load and bad-opcode beats: result registered on accept, one per cycle while not stalled
// read beats: memory read registered, then result registered in S_RESP, one at a time
// convert: the sequencer counts and prefix-sums columns, sorts, dedups, then counts and
//   prefix-sums rows and scatters column indices over the entry and pointer memories
// reset: asynchronous active low, clears counts and flags; stores hold garbage until written
module sparse_coordinate_to_compressed_core #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sctc_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sctc_pkg::out_t                 out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sctc_pkg::PADDR_W-1:0]   paddr,
    input  logic [sctc_pkg::PDATA_W-1:0]   pwdata,
    output logic [sctc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import sctc_pkg::*;

    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int CPD = MAX_COLS + 1;
    localparam int CPW = $clog2(MAX_COLS + 1);
    localparam int RPD = MAX_ROWS + 1;
    localparam int RPW = $clog2(MAX_ROWS + 1);
    localparam int CUD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int CUW = $clog2(CUD);
    localparam int SMW = $clog2(MAX_ROWS);
    localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'((MAX_ROWS < 256) ? MAX_ROWS : 256);
    localparam logic [DIM_W-1:0] COLS_RST = DIM_W'((MAX_COLS < 256) ? MAX_COLS : 256);
    localparam logic [CW-1:0] MAX_E = CW'(MAX_ENTRIES);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RESP     = 5'd1;
    localparam logic [4:0] S_CC_CLR   = 5'd2;
    localparam logic [4:0] S_CC_CNT_A = 5'd3;
    localparam logic [4:0] S_CC_CNT_B = 5'd4;
    localparam logic [4:0] S_CC_CNT_C = 5'd5;
    localparam logic [4:0] S_CC_PFX_A = 5'd6;
    localparam logic [4:0] S_CC_PFX_B = 5'd7;
    localparam logic [4:0] S_SORT_A   = 5'd8;
    localparam logic [4:0] S_SORT_B   = 5'd9;
    localparam logic [4:0] S_SORT_C   = 5'd10;
    localparam logic [4:0] S_SORT_D   = 5'd11;
    localparam logic [4:0] S_SORT_E   = 5'd12;
    localparam logic [4:0] S_SORT_F   = 5'd13;
    localparam logic [4:0] S_SORT_G   = 5'd14;
    localparam logic [4:0] S_DD_CLR   = 5'd15;
    localparam logic [4:0] S_DD_J     = 5'd16;
    localparam logic [4:0] S_DD_E     = 5'd17;
    localparam logic [4:0] S_DD_P     = 5'd18;
    localparam logic [4:0] S_DD_R     = 5'd19;
    localparam logic [4:0] S_DD_S     = 5'd20;
    localparam logic [4:0] S_CR_CLR   = 5'd21;
    localparam logic [4:0] S_CR_CNT_A = 5'd22;
    localparam logic [4:0] S_CR_CNT_B = 5'd23;
    localparam logic [4:0] S_CR_CNT_C = 5'd24;
    localparam logic [4:0] S_CR_PFX_A = 5'd25;
    localparam logic [4:0] S_CR_PFX_B = 5'd26;
    localparam logic [4:0] S_CS_J     = 5'd27;
    localparam logic [4:0] S_CS_E     = 5'd28;
    localparam logic [4:0] S_CS_P     = 5'd29;
    localparam logic [4:0] S_CS_R     = 5'd30;
    localparam logic [4:0] S_CS_W     = 5'd31;

    logic [4:0]       state_reg, state_next;
    logic [DIM_W-1:0] num_rows_reg, num_rows_next;
    logic [DIM_W-1:0] num_cols_reg, num_cols_next;
    logic             store_values_reg, store_values_next;
    logic [CW-1:0]    entry_count_reg, entry_count_next;
    logic [CW-1:0]    distinct_reg, distinct_next;
    logic             converted_reg, converted_next;
    logic [CW-1:0]    kp_reg, kp_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [CW-1:0]    w_reg, w_next;
    logic [CW-1:0]    acc_reg, acc_next;
    logic [CW-1:0]    end_reg, end_next;
    logic [CW-1:0]    start_reg, start_next;
    logic [CW-1:0]    sum_reg, sum_next;
    logic [CW-1:0]    l_reg, l_next;
    logic [ROW_W-1:0] r_reg, r_next;
    logic [ROW_W-1:0] rk_reg, rk_next;
    logic [ROW_W-1:0] jq_reg, jq_next;
    logic [VAL_W-1:0] vk_reg, vk_next;
    logic [1:0]       pend_status_reg, pend_status_next;
    logic [2:0]       pend_sel_reg, pend_sel_next;
    logic             pend_read_reg, pend_read_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_reg, out_next;

    logic [ROW_W-1:0] row_mem [MAX_ENTRIES];
    logic [ROW_W-1:0] col_mem [MAX_ENTRIES];
    logic [VAL_W-1:0] val_mem [MAX_ENTRIES];
    logic [CW-1:0]    cp_mem  [CPD];
    logic [CW-1:0]    rp_mem  [RPD];
    logic [CW-1:0]    cu_mem  [CUD];
    logic [DIM_W-1:0] sm_mem  [MAX_ROWS];

    logic             ri_re, ri_we, ci_re, ci_we, vs_re, vs_we;
    logic [EAW-1:0]   ri_ra, ri_wa, ci_ra, ci_wa, vs_ra, vs_wa;
    logic [ROW_W-1:0] ri_wd, ci_wd;
    logic [VAL_W-1:0] vs_wd;
    logic [ROW_W-1:0] ri_q_reg, ci_q_reg;
    logic [VAL_W-1:0] vs_q_reg;
    logic             cp_re, cp_we, rp_re, rp_we, cu_re, cu_we, sm_re, sm_we;
    logic [CPW-1:0]   cp_ra, cp_wa;
    logic [RPW-1:0]   rp_ra, rp_wa;
    logic [CUW-1:0]   cu_ra, cu_wa;
    logic [SMW-1:0]   sm_ra, sm_wa;
    logic [CW-1:0]    cp_wd, rp_wd, cu_wd;
    logic [DIM_W-1:0] sm_wd;
    logic [CW-1:0]    cp_q_reg, rp_q_reg, cu_q_reg;
    logic [DIM_W-1:0] sm_q_reg;

    logic [CW-1:0]    alu_a, alu_b, alu_c, alu_d, alu_sum;
    logic             alu_lt;

    logic             out_free, accept, cfg_write;
    logic [CW-1:0]    load_base;
    logic             read_ok;
    logic [VAL_W-1:0] resp_data;
    logic [DIM_W-1:0] cfg_dim;
    logic [DIM_W-1:0] j_inc;

    sctc_alu #(.W(CW)) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .d   (alu_d),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign load_base = converted_reg ? '0 : entry_count_reg;
    assign j_inc     = j_reg + DIM_W'(1);
    assign cfg_dim   = (pwdata[DIM_W-1:0] == '0) ? DIM_W'(1) : pwdata[DIM_W-1:0];

    always_comb
    begin
        read_ok = 1'b0;
        case (in_data.array_select)
            SEL_COLPTR: read_ok = 32'(in_data.read_index) <= 32'(num_cols_reg);
            SEL_ROWPTR: read_ok = 32'(in_data.read_index) <= 32'(num_rows_reg);
            default:
            begin
                if (in_data.array_select inside {SEL_ROWIDX, SEL_VALUE, SEL_COLIDX})
                    read_ok = 32'(in_data.read_index) < 32'(distinct_reg);
            end
        endcase
    end

    always_comb
    begin
        resp_data = '0;
        if (pend_read_reg && pend_status_reg == ST_OK)
        begin
            case (pend_sel_reg)
                SEL_COLPTR: resp_data = VAL_W'(cp_q_reg);
                SEL_ROWPTR: resp_data = VAL_W'(rp_q_reg);
                SEL_ROWIDX: resp_data = VAL_W'(ri_q_reg);
                SEL_COLIDX: resp_data = VAL_W'(ci_q_reg);
                SEL_VALUE:  resp_data = store_values_reg ? vs_q_reg : '0;
                default:    resp_data = '0;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_NUM_ROWS:     prdata = PDATA_W'(num_rows_reg);
            REG_NUM_COLS:     prdata = PDATA_W'(num_cols_reg);
            REG_STORE_VALUES: prdata = PDATA_W'(store_values_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        num_rows_next     = num_rows_reg;
        num_cols_next     = num_cols_reg;
        store_values_next = store_values_reg;
        entry_count_next  = entry_count_reg;
        distinct_next     = distinct_reg;
        converted_next    = converted_reg;
        kp_next           = kp_reg;
        j_next            = j_reg;
        w_next            = w_reg;
        acc_next          = acc_reg;
        end_next          = end_reg;
        start_next        = start_reg;
        sum_next          = sum_reg;
        l_next            = l_reg;
        r_next            = r_reg;
        rk_next           = rk_reg;
        jq_next           = jq_reg;
        vk_next           = vk_reg;
        pend_status_next  = pend_status_reg;
        pend_sel_next     = pend_sel_reg;
        pend_read_next    = pend_read_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_next          = out_reg;
        ri_re = 1'b0; ri_we = 1'b0; ri_ra = '0; ri_wa = '0; ri_wd = '0;
        ci_re = 1'b0; ci_we = 1'b0; ci_ra = '0; ci_wa = '0; ci_wd = '0;
        vs_re = 1'b0; vs_we = 1'b0; vs_ra = '0; vs_wa = '0; vs_wd = '0;
        cp_re = 1'b0; cp_we = 1'b0; cp_ra = '0; cp_wa = '0; cp_wd = '0;
        rp_re = 1'b0; rp_we = 1'b0; rp_ra = '0; rp_wa = '0; rp_wd = '0;
        cu_re = 1'b0; cu_we = 1'b0; cu_ra = '0; cu_wa = '0; cu_wd = '0;
        sm_re = 1'b0; sm_we = 1'b0; sm_ra = '0; sm_wa = '0; sm_wd = '0;
        alu_a = '0; alu_b = '0; alu_c = '0; alu_d = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.opcode)
                        OP_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            out_next.read_data = '0;
                            out_next.unique_count = UNQ_W'(distinct_reg);
                            out_next.status = ST_OK;
                            if (converted_reg)
                            begin
                                converted_next   = 1'b0;
                                entry_count_next = '0;
                            end
                            alu_c = load_base;
                            alu_d = MAX_E;
                            alu_a = load_base;
                            alu_b = CW'(1);
                            if (DIM_W'(in_data.row) >= num_rows_reg
                                || DIM_W'(in_data.col) >= num_cols_reg)
                                out_next.status = ST_RANGE;
                            else if (!alu_lt)
                                out_next.status = ST_FULL;
                            else
                            begin
                                ri_we = 1'b1; ri_wa = EAW'(load_base); ri_wd = in_data.row;
                                ci_we = 1'b1; ci_wa = EAW'(load_base); ci_wd = in_data.col;
                                vs_we = 1'b1; vs_wa = EAW'(load_base);
                                vs_wd = store_values_reg ? in_data.entry_value : '0;
                                entry_count_next = alu_sum;
                            end
                        end
                        OP_CONVERT:
                        begin
                            pend_status_next = ST_OK;
                            pend_read_next   = 1'b0;
                            if (converted_reg)
                                state_next = S_RESP;
                            else
                            begin
                                j_next     = '0;
                                state_next = S_CC_CLR;
                            end
                        end
                        OP_READ:
                        begin
                            pend_read_next = 1'b1;
                            pend_sel_next  = in_data.array_select;
                            state_next     = S_RESP;
                            if (!converted_reg)
                                pend_status_next = ST_NOT_CONV;
                            else if (!read_ok)
                                pend_status_next = ST_RANGE;
                            else
                            begin
                                pend_status_next = ST_OK;
                                cp_ra = CPW'(in_data.read_index);
                                rp_ra = RPW'(in_data.read_index);
                                ri_ra = EAW'(in_data.read_index);
                                ci_ra = EAW'(in_data.read_index);
                                vs_ra = EAW'(in_data.read_index);
                                case (in_data.array_select)
                                    SEL_COLPTR: cp_re = 1'b1;
                                    SEL_ROWPTR: rp_re = 1'b1;
                                    SEL_ROWIDX: ri_re = 1'b1;
                                    SEL_COLIDX: ci_re = 1'b1;
                                    default:    vs_re = 1'b1;
                                endcase
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_next.status = ST_RANGE;
                            out_next.read_data = '0;
                            out_next.unique_count = UNQ_W'(distinct_reg);
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.status = pend_status_reg;
                    out_next.read_data = resp_data;
                    out_next.unique_count = UNQ_W'(distinct_reg);
                    state_next = S_IDLE;
                end
            end
            S_CC_CLR:
            begin
                cu_we = 1'b1; cu_wa = CUW'(j_reg); cu_wd = '0;
                cp_we = (j_reg == '0); cp_wa = '0; cp_wd = '0;
                if (j_inc == num_cols_reg)
                begin
                    kp_next    = '0;
                    state_next = S_CC_CNT_A;
                end
                else
                    j_next = j_inc;
            end
            S_CC_CNT_A:
            begin
                alu_c = kp_reg; alu_d = entry_count_reg;
                if (!alu_lt)
                begin
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = S_CC_PFX_A;
                end
                else
                begin
                    ci_re = 1'b1; ci_ra = EAW'(kp_reg);
                    state_next = S_CC_CNT_B;
                end
            end
            S_CC_CNT_B:
            begin
                if (DIM_W'(ci_q_reg) < num_cols_reg)
                begin
                    cu_re = 1'b1; cu_ra = CUW'(ci_q_reg);
                    state_next = S_CC_CNT_C;
                end
                else
                begin
                    kp_next    = kp_reg + CW'(1);
                    state_next = S_CC_CNT_A;
                end
            end
            S_CC_CNT_C:
            begin
                alu_a = cu_q_reg; alu_b = CW'(1);
                cu_we = 1'b1; cu_wa = CUW'(ci_q_reg); cu_wd = alu_sum;
                kp_next    = kp_reg + CW'(1);
                state_next = S_CC_CNT_A;
            end
            S_CC_PFX_A:
            begin
                cu_re = 1'b1; cu_ra = CUW'(j_reg);
                state_next = S_CC_PFX_B;
            end
            S_CC_PFX_B:
            begin
                alu_a = acc_reg; alu_b = cu_q_reg;
                cp_we = 1'b1; cp_wa = CPW'(j_inc); cp_wd = alu_sum;
                cu_we = 1'b1; cu_wa = CUW'(j_reg); cu_wd = acc_reg;
                acc_next = alu_sum;
                if (j_inc == num_cols_reg)
                begin
                    kp_next    = '0;
                    state_next = S_SORT_A;
                end
                else
                begin
                    j_next     = j_inc;
                    state_next = S_CC_PFX_A;
                end
            end
            S_SORT_A:
            begin
                alu_c = kp_reg; alu_d = entry_count_reg;
                if (!alu_lt)
                begin
                    j_next     = '0;
                    state_next = S_DD_CLR;
                end
                else
                begin
                    ci_re = 1'b1; ci_ra = EAW'(kp_reg);
                    ri_re = 1'b1; ri_ra = EAW'(kp_reg);
                    vs_re = 1'b1; vs_ra = EAW'(kp_reg);
                    state_next = S_SORT_B;
                end
            end
            S_SORT_B:
            begin
                if (DIM_W'(ci_q_reg) >= num_cols_reg)
                begin
                    j_next     = '0;
                    state_next = S_DD_CLR;
                end
                else
                begin
                    jq_next = ci_q_reg;
                    rk_next = ri_q_reg;
                    vk_next = vs_q_reg;
                    cp_re = 1'b1; cp_ra = CPW'(ci_q_reg);
                    cu_re = 1'b1; cu_ra = CUW'(ci_q_reg);
                    state_next = S_SORT_C;
                end
            end
            S_SORT_C:
            begin
                alu_c = kp_reg; alu_d = cp_q_reg;
                alu_a = kp_reg; alu_b = CW'(1);
                sum_next   = alu_sum;
                state_next = alu_lt ? S_SORT_G : S_SORT_F;
            end
            S_SORT_F:
            begin
                alu_c = sum_reg; alu_d = cu_q_reg;
                kp_next    = alu_lt ? cu_q_reg : sum_reg;
                state_next = S_SORT_A;
            end
            S_SORT_G:
            begin
                alu_a = cu_q_reg; alu_b = CW'(1);
                alu_c = cu_q_reg; alu_d = entry_count_reg;
                cu_we = 1'b1; cu_wa = CUW'(jq_reg); cu_wd = alu_sum;
                l_next = cu_q_reg;
                if (!alu_lt)
                begin
                    j_next     = '0;
                    state_next = S_DD_CLR;
                end
                else
                begin
                    ri_re = 1'b1; ri_ra = EAW'(cu_q_reg);
                    ci_re = 1'b1; ci_ra = EAW'(cu_q_reg);
                    vs_re = 1'b1; vs_ra = EAW'(cu_q_reg);
                    state_next = S_SORT_D;
                end
            end
            S_SORT_D:
            begin
                ri_we = 1'b1; ri_wa = EAW'(kp_reg); ri_wd = ri_q_reg;
                ci_we = 1'b1; ci_wa = EAW'(kp_reg); ci_wd = ci_q_reg;
                vs_we = store_values_reg; vs_wa = EAW'(kp_reg); vs_wd = vs_q_reg;
                state_next = S_SORT_E;
            end
            S_SORT_E:
            begin
                ri_we = 1'b1; ri_wa = EAW'(l_reg); ri_wd = rk_reg;
                ci_we = 1'b1; ci_wa = EAW'(l_reg); ci_wd = jq_reg;
                vs_we = store_values_reg; vs_wa = EAW'(l_reg); vs_wd = vk_reg;
                state_next = S_SORT_A;
            end
            S_DD_CLR:
            begin
                sm_we = 1'b1; sm_wa = SMW'(j_reg); sm_wd = '0;
                if (j_inc == num_rows_reg)
                begin
                    j_next     = '0;
                    w_next     = '0;
                    kp_next    = '0;
                    state_next = S_DD_J;
                end
                else
                    j_next = j_inc;
            end
            S_DD_J:
            begin
                if (j_reg == num_cols_reg)
                begin
                    cp_we = 1'b1; cp_wa = CPW'(num_cols_reg); cp_wd = w_reg;
                    distinct_next = w_reg;
                    j_next        = '0;
                    state_next    = S_CR_CLR;
                end
                else
                begin
                    cp_re = 1'b1; cp_ra = CPW'(j_inc);
                    start_next = w_reg;
                    state_next = S_DD_E;
                end
            end
            S_DD_E:
            begin
                end_next   = cp_q_reg;
                state_next = S_DD_P;
            end
            S_DD_P:
            begin
                alu_c = kp_reg; alu_d = end_reg;
                if (alu_lt)
                begin
                    ri_re = 1'b1; ri_ra = EAW'(kp_reg);
                    vs_re = 1'b1; vs_ra = EAW'(kp_reg);
                    state_next = S_DD_R;
                end
                else
                begin
                    cp_we = 1'b1; cp_wa = CPW'(j_reg); cp_wd = start_reg;
                    j_next     = j_inc;
                    state_next = S_DD_J;
                end
            end
            S_DD_R:
            begin
                r_next = ri_q_reg;
                sm_re = (DIM_W'(ri_q_reg) < num_rows_reg); sm_ra = SMW'(ri_q_reg);
                state_next = S_DD_S;
            end
            S_DD_S:
            begin
                alu_a = w_reg; alu_b = CW'(1);
                if (DIM_W'(r_reg) < num_rows_reg && sm_q_reg != j_inc)
                begin
                    ri_we = 1'b1; ri_wa = EAW'(w_reg); ri_wd = r_reg;
                    sm_we = 1'b1; sm_wa = SMW'(r_reg); sm_wd = j_inc;
                    vs_we = store_values_reg; vs_wa = EAW'(w_reg); vs_wd = vs_q_reg;
                    w_next = alu_sum;
                end
                kp_next    = kp_reg + CW'(1);
                state_next = S_DD_P;
            end
            S_CR_CLR:
            begin
                cu_we = 1'b1; cu_wa = CUW'(j_reg); cu_wd = '0;
                if (j_inc == num_rows_reg)
                begin
                    kp_next    = '0;
                    state_next = S_CR_CNT_A;
                end
                else
                    j_next = j_inc;
            end
            S_CR_CNT_A:
            begin
                alu_c = kp_reg; alu_d = distinct_reg;
                if (!alu_lt)
                begin
                    rp_we = 1'b1; rp_wa = '0; rp_wd = '0;
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = S_CR_PFX_A;
                end
                else
                begin
                    ri_re = 1'b1; ri_ra = EAW'(kp_reg);
                    state_next = S_CR_CNT_B;
                end
            end
            S_CR_CNT_B:
            begin
                if (DIM_W'(ri_q_reg) < num_rows_reg)
                begin
                    cu_re = 1'b1; cu_ra = CUW'(ri_q_reg);
                    state_next = S_CR_CNT_C;
                end
                else
                begin
                    kp_next    = kp_reg + CW'(1);
                    state_next = S_CR_CNT_A;
                end
            end
            S_CR_CNT_C:
            begin
                alu_a = cu_q_reg; alu_b = CW'(1);
                cu_we = 1'b1; cu_wa = CUW'(ri_q_reg); cu_wd = alu_sum;
                kp_next    = kp_reg + CW'(1);
                state_next = S_CR_CNT_A;
            end
            S_CR_PFX_A:
            begin
                cu_re = 1'b1; cu_ra = CUW'(j_reg);
                state_next = S_CR_PFX_B;
            end
            S_CR_PFX_B:
            begin
                alu_a = acc_reg; alu_b = cu_q_reg;
                rp_we = 1'b1; rp_wa = RPW'(j_inc); rp_wd = alu_sum;
                cu_we = 1'b1; cu_wa = CUW'(j_reg); cu_wd = acc_reg;
                acc_next = alu_sum;
                if (j_inc == num_rows_reg)
                begin
                    j_next     = '0;
                    kp_next    = '0;
                    state_next = S_CS_J;
                end
                else
                begin
                    j_next     = j_inc;
                    state_next = S_CR_PFX_A;
                end
            end
            S_CS_J:
            begin
                if (j_reg == num_cols_reg)
                begin
                    converted_next = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    cp_re = 1'b1; cp_ra = CPW'(j_inc);
                    state_next = S_CS_E;
                end
            end
            S_CS_E:
            begin
                end_next   = cp_q_reg;
                state_next = S_CS_P;
            end
            S_CS_P:
            begin
                alu_c = kp_reg; alu_d = end_reg;
                if (alu_lt)
                begin
                    ri_re = 1'b1; ri_ra = EAW'(kp_reg);
                    state_next = S_CS_R;
                end
                else
                begin
                    j_next     = j_inc;
                    state_next = S_CS_J;
                end
            end
            S_CS_R:
            begin
                if (DIM_W'(ri_q_reg) < num_rows_reg)
                begin
                    cu_re = 1'b1; cu_ra = CUW'(ri_q_reg);
                    state_next = S_CS_W;
                end
                else
                begin
                    kp_next    = kp_reg + CW'(1);
                    state_next = S_CS_P;
                end
            end
            S_CS_W:
            begin
                alu_a = cu_q_reg; alu_b = CW'(1);
                alu_c = cu_q_reg; alu_d = MAX_E;
                if (alu_lt)
                begin
                    ci_we = 1'b1; ci_wa = EAW'(cu_q_reg); ci_wd = ROW_W'(j_reg);
                    cu_we = 1'b1; cu_wa = CUW'(ri_q_reg); cu_wd = alu_sum;
                end
                kp_next    = kp_reg + CW'(1);
                state_next = S_CS_P;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_NUM_ROWS:
                begin
                    num_rows_next = (32'(cfg_dim) > 32'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg_dim;
                    entry_count_next = '0;
                    converted_next   = 1'b0;
                end
                REG_NUM_COLS:
                begin
                    num_cols_next = (32'(cfg_dim) > 32'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg_dim;
                    entry_count_next = '0;
                    converted_next   = 1'b0;
                end
                REG_STORE_VALUES:
                begin
                    store_values_next = pwdata[0];
                end
                default:
                begin
                    store_values_next = store_values_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            num_rows_reg     <= ROWS_RST;
            num_cols_reg     <= COLS_RST;
            store_values_reg <= 1'b1;
            entry_count_reg  <= '0;
            distinct_reg     <= '0;
            converted_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            pend_read_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            num_rows_reg     <= num_rows_next;
            num_cols_reg     <= num_cols_next;
            store_values_reg <= store_values_next;
            entry_count_reg  <= entry_count_next;
            distinct_reg     <= distinct_next;
            converted_reg    <= converted_next;
            out_valid_reg    <= out_valid_next;
            pend_read_reg    <= pend_read_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kp_reg          <= kp_next;
        j_reg           <= j_next;
        w_reg           <= w_next;
        acc_reg         <= acc_next;
        end_reg         <= end_next;
        start_reg       <= start_next;
        sum_reg         <= sum_next;
        l_reg           <= l_next;
        r_reg           <= r_next;
        rk_reg          <= rk_next;
        jq_reg          <= jq_next;
        vk_reg          <= vk_next;
        pend_status_reg <= pend_status_next;
        pend_sel_reg    <= pend_sel_next;
        out_reg         <= out_next;
    end

    // entry stores
    always_ff @(posedge clk)
    begin
        if (ri_we)
            row_mem[ri_wa] <= ri_wd;
        if (ri_re)
            ri_q_reg <= row_mem[ri_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ci_we)
            col_mem[ci_wa] <= ci_wd;
        if (ci_re)
            ci_q_reg <= col_mem[ci_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vs_we)
            val_mem[vs_wa] <= vs_wd;
        if (vs_re)
            vs_q_reg <= val_mem[vs_ra];
    end

    // pointer, cursor and mark stores
    always_ff @(posedge clk)
    begin
        if (cp_we)
            cp_mem[cp_wa] <= cp_wd;
        if (cp_re)
            cp_q_reg <= cp_mem[cp_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rp_we)
            rp_mem[rp_wa] <= rp_wd;
        if (rp_re)
            rp_q_reg <= rp_mem[rp_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cu_we)
            cu_mem[cu_wa] <= cu_wd;
        if (cu_re)
            cu_q_reg <= cu_mem[cu_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
            sm_mem[sm_wa] <= sm_wd;
        if (sm_re)
            sm_q_reg <= sm_mem[sm_ra];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= MAX_E)
        else $error("entry count beyond store depth");

    a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        converted_reg |-> distinct_reg <= entry_count_reg)
        else $error("distinct count exceeds loaded entries");

    a_convert_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(converted_reg) |-> state_reg == S_RESP)
        else $error("conversion finished without a result beat");

endmodule
